// File: hw/rtl/ppu_pkg.sv
package ppu_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned NumW    = 83;   // |numerator| << 16, magnitude
  localparam int unsigned DenW    = 65;   // |difference| * |z|
  localparam int unsigned QuotW   = 34;   // quotient bits kept; overflow is flagged in lane_t.big
  localparam int unsigned DivStg  = 17;   // two quotient bits per stage

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadFrus = 2'd1,
    StatusZeroZ   = 2'd2
  } status_e;

  typedef enum logic [RegIdxW-1:0] {
    RegLeft   = 3'd0,
    RegRight  = 3'd1,
    RegTop    = 3'd2,
    RegBottom = 3'd3,
    RegNear   = 3'd4,
    RegFar    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [WordW-1:0] left;
    logic signed [WordW-1:0] right;
    logic signed [WordW-1:0] top;
    logic signed [WordW-1:0] bottom;
    logic signed [WordW-1:0] near;
    logic signed [WordW-1:0] far;
  } frustum_t;

  // One quotient lane inside the divider.
  typedef struct packed {
    logic            neg;
    logic            big;    // numerator too large for a QuotW-bit quotient
    logic [NumW-1:0] rem;    // high numerator bits, then partial remainder
    logic [QuotW-1:0] quo;
    logic [DenW-1:0] den;
  } lane_t;

  typedef struct packed {
    logic             neg;
    logic [NumW-1:0]  num;
    logic [DenW-1:0]  den;
  } frac_t;

  typedef struct packed {
    frac_t   [2:0] f;
    status_e       status;
  } setup_t;

endpackage

// File: hw/rtl/ppu_if.sv
interface ppu_if #(
  parameter int unsigned W = 96
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ppu_setup.sv
// Two-stage front end: products, then signed sums into magnitude fractions.
module ppu_setup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               valid_i,
  input  ppu_pkg::frustum_t  cfg_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] z_i,
  output logic               valid_o,
  output ppu_pkg::setup_t    setup_o
);
  import ppu_pkg::*;

  logic v1_q, v2_q;
  logic signed [65:0] pa_q [3];
  logic signed [65:0] pb_q [3];
  logic [DenW-1:0]    den_q [3];
  logic               dneg_q [3];
  status_e            st1_q;
  setup_t             s2_q;

  logic signed [32:0] l, r, t, b, n, f, dx, dy, dz, n2;
  logic signed [33:0] sx, sy, sz;
  logic [32:0]        az;
  logic               bad;

  always_comb begin
    l = 33'(cfg_i.left);  r = 33'(cfg_i.right);
    t = 33'(cfg_i.top);   b = 33'(cfg_i.bottom);
    n = 33'(cfg_i.near);  f = 33'(cfg_i.far);
    dx = r - l; dy = t - b; dz = f - n;
    n2 = n <<< 1;
    sx = 34'(r) + 34'(l);
    sy = 34'(t) + 34'(b);
    sz = 34'(f) + 34'(n);
    az = z_i[31] ? 33'(-34'(z_i)) : 33'(z_i);
    bad = (n <= 0) || (f <= 0) || (dx <= 0) || (dy <= 0) || (dz <= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      pa_q[0] <= 66'(n2) * 66'(x_i);
      pb_q[0] <= 66'(sx) * 66'(z_i);
      pa_q[1] <= 66'(n2) * 66'(y_i);
      pb_q[1] <= 66'(sy) * 66'(z_i);
      pa_q[2] <= 66'(sz) * 66'(z_i);
      pb_q[2] <= 66'(n2) * 66'(f);
      den_q[0] <= DenW'(dx[31:0]) * DenW'(az);
      den_q[1] <= DenW'(dy[31:0]) * DenW'(az);
      den_q[2] <= DenW'(dz[31:0]) * DenW'(az);
      dneg_q[0] <= ~z_i[31] && (z_i != '0);
      dneg_q[1] <= ~z_i[31] && (z_i != '0);
      dneg_q[2] <= z_i[31];
      st1_q <= bad ? StatusBadFrus : ((z_i == '0) ? StatusZeroZ : StatusOk);
    end
  end

  logic signed [66:0] sum [3];
  logic [66:0]        mag [3];
  setup_t             s2_d;

  always_comb begin
    s2_d.status = st1_q;
    for (int i = 0; i < 3; i++) begin
      sum[i] = 67'(pa_q[i]) + 67'(pb_q[i]);
      mag[i] = sum[i][66] ? 67'(-sum[i]) : 67'(sum[i]);
      s2_d.f[i].neg = sum[i][66] ^ dneg_q[i];
      s2_d.f[i].num = {mag[i][66:0], 16'h0};
      s2_d.f[i].den = (st1_q == StatusOk) ? den_q[i] : DenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) s2_q <= s2_d;
  end

  assign valid_o = v2_q;
  assign setup_o = s2_q;
endmodule

// File: hw/rtl/ppu_div.sv
// Pipelined restoring divider, two quotient bits per stage, three lanes.
// Only the low 34 quotient bits are formed; any higher numerator bits that
// would produce a quotient bit of one are flagged as overflow up front.
module ppu_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             valid_i,
  input  ppu_pkg::setup_t  setup_i,
  output logic             valid_o,
  output ppu_pkg::lane_t [2:0] lane_o,
  output ppu_pkg::status_e status_o
);
  import ppu_pkg::*;

  lane_t   [2:0] lane_q [DivStg+1];
  status_e       st_q   [DivStg+1];
  logic          v_q    [DivStg+1];

  lane_t   [2:0] first_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      first_d[i].neg = setup_i.f[i].neg;
      first_d[i].den = setup_i.f[i].den;
      // high part / den must be zero for the quotient to fit in QuotW bits
      first_d[i].big = {16'h0, setup_i.f[i].num[NumW-1:QuotW]} >= setup_i.f[i].den;
      first_d[i].rem = {{QuotW{1'b0}}, setup_i.f[i].num[NumW-1:QuotW]};
      first_d[i].quo = setup_i.f[i].num[QuotW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DivStg; s++) v_q[s] <= 1'b0;
    end else if (advance_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s <= DivStg; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      lane_q[0] <= first_d;
      st_q[0]   <= setup_i.status;
      for (int s = 1; s <= DivStg; s++) st_q[s] <= st_q[s-1];
    end
  end

  // rem holds the partial remainder (< den unless big); quo shifts numerator bits out
  // at the top and quotient bits in at the bottom.
  for (genvar s = 1; s <= DivStg; s++) begin : g_stage
    lane_t [2:0] nx;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        lane_t   c;
        logic [DenW:0] tr;
        c = lane_q[s-1][i];
        for (int k = 0; k < 2; k++) begin
          tr = {c.rem[DenW-1:0], c.quo[QuotW-1]};
          c.quo = {c.quo[QuotW-2:0], 1'b0};
          if (tr >= {1'b0, c.den}) begin
            tr = tr - {1'b0, c.den};
            c.quo[0] = 1'b1;
          end
          c.rem = NumW'(tr[DenW-1:0]);
        end
        nx[i] = c;
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance_i) lane_q[s] <= nx;
    end
  end

  assign valid_o  = v_q[DivStg];
  assign lane_o   = lane_q[DivStg];
  assign status_o = st_q[DivStg];
endmodule

// File: hw/rtl/perspective_point_projection_unit.sv
// Channel | Dir | Payload
// in_if   | in  | point_x [31:0], point_y [63:32], point_z [95:64]
// out_if  | out | ndc_x [31:0], ndc_y [63:32], ndc_z [95:64], status [97:96]
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// One item per cycle sustained while out_if.ready is high; the pipe has two setup stages for the
// products and sums, one divider entry stage and 17 divider stages at two
// quotient bits each, and one output stage. Reset clears all valid bits and
// loads the default frustum.
// A stall freezes the whole pipe; in_if.ready follows out_if.ready or an
// empty output register.
module perspective_point_projection_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ppu_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [ppu_pkg::WordW-1:0]    cfg_data_i,
  ppu_if.sink                          in_if,
  ppu_if.source                        out_if
);
  import ppu_pkg::*;

  frustum_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left   <= -32'sd65536;
      cfg_q.right  <= 32'sd65536;
      cfg_q.top    <= 32'sd65536;
      cfg_q.bottom <= -32'sd65536;
      cfg_q.near   <= 32'sd65536;
      cfg_q.far    <= 32'sd6553600;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLeft:   cfg_q.left   <= cfg_data_i;
        RegRight:  cfg_q.right  <= cfg_data_i;
        RegTop:    cfg_q.top    <= cfg_data_i;
        RegBottom: cfg_q.bottom <= cfg_data_i;
        RegNear:   cfg_q.near   <= cfg_data_i;
        RegFar:    cfg_q.far    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_v_q;
  logic [97:0] out_q;
  logic advance;
  assign advance = out_if.ready || !out_v_q;
  assign in_if.ready = advance;

  logic    sv, dv;
  setup_t  su;
  lane_t [2:0] ln;
  status_e st;

  ppu_setup u_setup (
    .clk_i, .rst_ni, .advance_i(advance),
    .valid_i(in_if.valid), .cfg_i(cfg_q),
    .x_i(in_if.data[31:0]), .y_i(in_if.data[63:32]), .z_i(in_if.data[95:64]),
    .valid_o(sv), .setup_o(su)
  );

  ppu_div u_div (
    .clk_i, .rst_ni, .advance_i(advance), .valid_i(sv), .setup_i(su),
    .valid_o(dv), .lane_o(ln), .status_o(st)
  );

  logic [31:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (st != StatusOk) begin
        res[i] = '0;
      end else if (ln[i].neg) begin
        if (ln[i].big || ln[i].quo > 34'h080000000) res[i] = 32'h80000000;
        else res[i] = 32'(-ln[i].quo);
      end else begin
        if (ln[i].big || ln[i].quo > 34'h07FFFFFFF) res[i] = 32'h7FFFFFFF;
        else res[i] = ln[i].quo[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (advance) out_v_q <= dv;
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= {st, res[2], res[1], res[0]};
  end

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;
endmodule

// File: test/tb_perspective_point_projection_unit.sv
`timescale 1ns / 1ps

module tb_perspective_point_projection_unit;
  import ppu_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [WordW-1:0] cfg_data_i;

  ppu_if #(.W(96)) in_ch ();
  ppu_if #(.W(98)) out_ch ();

  perspective_point_projection_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  logic [WordW-1:0] frustum_q [NumRegs];
  logic [97:0] ndc_queue [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit steady;   // no idling on either side while set

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [31:0] sat_quot(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (q < -128'sh8000_0000) return 32'h8000_0000;
    return q[31:0];
  endfunction

  // Exact rational projection, truncated toward zero, then saturated.
  function automatic logic [97:0] project_point(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz);
    logic signed [127:0] l, r, t, b, n, f, x, y, z;
    logic [31:0] nx, ny, nz;
    l = $signed(frustum_q[RegLeft]);
    r = $signed(frustum_q[RegRight]);
    t = $signed(frustum_q[RegTop]);
    b = $signed(frustum_q[RegBottom]);
    n = $signed(frustum_q[RegNear]);
    f = $signed(frustum_q[RegFar]);
    x = $signed(px);
    y = $signed(py);
    z = $signed(pz);
    if (n <= 0 || f <= 0 || r - l <= 0 || t - b <= 0 || f - n <= 0)
      return {StatusBadFrus, 96'd0};
    if (z == 0) return {StatusZeroZ, 96'd0};
    nx = sat_quot((2 * n * x + (r + l) * z) <<< 16, (r - l) * (-z));
    ny = sat_quot((2 * n * y + (t + b) * z) <<< 16, (t - b) * (-z));
    nz = sat_quot(((f + n) * z + 2 * n * f) <<< 16, (f - n) * z);
    return {StatusOk, nz, ny, nx};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      3: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      4: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3) :
                                    32'h8000_0000 + $urandom_range(3);
      default: return $urandom_range(7) == 0 ? 32'd0 : -32'($urandom_range(1, 50 << 16));
    endcase
  endfunction

  // Drop the input and let the pipe empty before touching a register.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    in_ch.valid <= 1'b0;
    while (ndc_queue.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frustum_q[idx] = value;
  endtask

  task automatic set_frustum(logic [31:0] l, logic [31:0] r, logic [31:0] t,
                             logic [31:0] b, logic [31:0] n, logic [31:0] f);
    while (ndc_queue.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    write_reg(RegLeft, l);
    write_reg(RegRight, r);
    write_reg(RegTop, t);
    write_reg(RegBottom, b);
    write_reg(RegNear, n);
    write_reg(RegFar, f);
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    in_ch.valid <= 1'b1;
    in_ch.data  <= {pz, py, px};
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    ndc_queue.push_back(project_point(px, py, pz));
    if (!steady && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      steady = (i % 400) >= 300;
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_point(32'd0, 32'd0, -32'sd65536);
    send_point(32'h0001_0000, 32'hFFFF_0000, -32'sd65536);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, -32'sd65536);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h0003_0000, 32'h0002_0000, 32'd0);
    send_point(32'h0000_8000, 32'h0000_4000, 32'h0000_0001);
    send_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_point(32'h0001_0000, 32'h0001_0000, -32'sd6553600);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0064_0000);
    in_ch.valid <= 1'b0;
  endtask

  task automatic test_bad_frustum();
    set_frustum(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
                32'd0, 32'h0064_0000);
    send_point(32'h0001_0000, 32'h0001_0000, -32'sd65536);
    send_point(32'h0001_0000, 32'h0001_0000, 32'd0);
    write_reg(RegNear, 32'h0001_0000);
    write_reg(RegFar, 32'hFFFF_0000);
    send_point(32'h0001_0000, 32'h0001_0000, -32'sd65536);
    write_reg(RegFar, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0001_0000, -32'sd65536);
    write_reg(RegFar, 32'h0064_0000);
    write_reg(RegRight, 32'hFFFF_0000);
    send_point(32'h0001_0000, 32'h0001_0000, -32'sd65536);
    write_reg(RegRight, 32'h0001_0000);
    write_reg(RegTop, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0001_0000, -32'sd65536);
    in_ch.valid <= 1'b0;
    // Index beyond the register file is ignored.
    while (ndc_queue.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 3'(RegFar) + 3'd1;
    cfg_data_i <= 32'h1234_5678;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_random(100);
  endtask

  task automatic test_extreme_frustum();
    set_frustum(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0000_0001, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
    send_random(300);
    set_frustum(32'h7FFF_FFFD, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
                32'h7FFF_FFFE, 32'h7FFF_FFFF);
    send_random(300);
  endtask

  task automatic test_random_frustums();
    for (int k = 0; k < 6; k++) begin
      logic [31:0] l, b, n;
      l = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      b = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      n = $urandom_range(1, 4 << 16);
      set_frustum(l, l + $urandom_range(1, 8 << 16), b + $urandom_range(1, 8 << 16), b,
                  n, n + $urandom_range(1, 200 << 16));
      send_random(200);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    logic [97:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (ndc_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h", out_ch.data);
      end else begin
        want = ndc_queue.pop_front();
        if (out_ch.data[31:0] !== want[31:0] || out_ch.data[63:32] !== want[63:32] ||
            out_ch.data[95:64] !== want[95:64] || out_ch.data[97:96] !== want[97:96]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: x %h/%h y %h/%h z %h/%h status %0d/%0d (expected/actual)",
                     want[31:0], out_ch.data[31:0], want[63:32], out_ch.data[63:32],
                     want[95:64], out_ch.data[95:64], want[97:96], out_ch.data[97:96]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && ndc_queue.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("perspective_point_projection_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegLeft;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    frustum_q[RegLeft]   = 32'hFFFF_0000;
    frustum_q[RegRight]  = 32'h0001_0000;
    frustum_q[RegTop]    = 32'h0001_0000;
    frustum_q[RegBottom] = 32'hFFFF_0000;
    frustum_q[RegNear]   = 32'h0001_0000;
    frustum_q[RegFar]    = 32'h0064_0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_random(300);
    test_bad_frustum();
    test_extreme_frustum();
    test_random_frustums();
    while (ndc_queue.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && ndc_queue.size() == 0) begin
      $display("perspective_point_projection_unit test passed");
    end else begin
      $display("perspective_point_projection_unit test failed");
    end
    $finish;
  end

endmodule
